// File: src/fra_pkg.sv
package fra_pkg;

  // fixed field widths
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 2;

  // default pool size
  localparam int POOL_SIZE_DEF = 64;

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_OWNED = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

endpackage

// File: src/fra_req_if.sv
interface fra_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [fra_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, output kind, output handle, input ready);
  modport sink   (input valid, input kind, input handle, output ready);
endinterface

// File: src/fra_rsp_if.sv
interface fra_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fra_pkg::HANDLE_W-1:0] granted_handle;
  logic [fra_pkg::STATUS_W-1:0] status;

  modport source (output valid, output granted_handle, output status, input ready);
  modport sink   (input valid, input granted_handle, input status, output ready);
endinterface

// File: src/fra_ram.sv
module fra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fifo_reuse_handle_allocator.sv
// handle allocator: released handles are reused oldest first, else fresh ones are minted
// result: registered, and shows in the cycle after the item is accepted
// throughput: one item per cycle while the result is taken; ownership bits and all counters are read and
//   updated in the accepting cycle, the free fifo ram is read ahead at its head
// reset: ownership bits, fifo pointers and counts cleared at once, no clearing pass;
//   the free fifo ram is not cleared, an entry is only read after it is written
module fifo_reuse_handle_allocator #(
  parameter int POOL_SIZE = fra_pkg::POOL_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fra_req_if.sink   in_ch,
  fra_rsp_if.source out_ch
);

  localparam int HW        = fra_pkg::HANDLE_W;
  localparam int PTR_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  // only handles that fit the handle field can ever be released
  localparam int OWN_DEPTH = (POOL_SIZE < (1 << HW)) ? POOL_SIZE : (1 << HW);
  localparam int OWN_W     = $clog2(OWN_DEPTH);

  logic [PTR_W-1:0]     head_r, tail_r, head_nxt;
  logic [CNT_W-1:0]     count_r, fresh_r;
  logic [OWN_DEPTH-1:0] owned_r;
  logic                 out_valid_r;
  logic [HW-1:0]        granted_r, granted_nxt;
  fra_pkg::status_t     status_r, status_nxt;
  logic                 byp_r, byp_nxt;
  logic [HW-1:0]        byp_data_r;
  logic [HW-1:0]        ram_rdata, head_val;

  logic                 in_ready, acc;
  logic                 pop, mint, push, own_we, own_val;
  logic [OWN_W-1:0]     own_idx;
  logic                 rel_in_range, head_in_range, fresh_in_range;
  logic                 ram_we;

  // handshake: the result register frees up when taken
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign acc          = in_ch.valid && in_ready;

  // fifo head value, with bypass for a write that hit the read address
  assign head_val = byp_r ? byp_data_r : ram_rdata;

  assign rel_in_range   = {1'b0, in_ch.handle} < (HW + 1)'(OWN_DEPTH);
  assign head_in_range  = {1'b0, head_val} < (HW + 1)'(OWN_DEPTH);
  assign fresh_in_range = fresh_r < CNT_W'(OWN_DEPTH);

  // decode one request
  always_comb begin
    granted_nxt = '0;
    status_nxt  = fra_pkg::ST_OK;
    pop         = 1'b0;
    mint        = 1'b0;
    push        = 1'b0;
    own_we      = 1'b0;
    own_val     = 1'b0;
    own_idx     = '0;
    if (in_ch.kind == fra_pkg::KIND_ALLOC) begin
      if (count_r != '0) begin
        granted_nxt = head_val;
        pop         = 1'b1;
        own_we      = head_in_range;
        own_val     = 1'b1;
        own_idx     = head_val[OWN_W-1:0];
      end else if (fresh_r < CNT_W'(POOL_SIZE)) begin
        granted_nxt = HW'(fresh_r);
        mint        = 1'b1;
        own_we      = fresh_in_range;
        own_val     = 1'b1;
        own_idx     = fresh_r[OWN_W-1:0];
      end else begin
        status_nxt = fra_pkg::ST_EXHAUSTED;
      end
    end else begin
      if (!rel_in_range || !owned_r[in_ch.handle[OWN_W-1:0]]) begin
        status_nxt = fra_pkg::ST_NOT_OWNED;
      end else begin
        own_we  = 1'b1;
        own_val = 1'b0;
        own_idx = in_ch.handle[OWN_W-1:0];
        push    = count_r < CNT_W'(POOL_SIZE);
      end
    end
  end

  // next head position drives the read-ahead address
  always_comb begin
    head_nxt = head_r;
    if (acc && pop) begin
      head_nxt = (head_r == PTR_W'(POOL_SIZE - 1)) ? '0 : head_r + 1'b1;
    end
  end

  assign ram_we  = acc && push;
  assign byp_nxt = ram_we && (tail_r == head_nxt);

  fra_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_SIZE)
  ) u_free_fifo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_ch.handle),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      owned_r     <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      head_r <= head_nxt;
      byp_r  <= byp_nxt;
      if (acc) begin
        if (push) begin
          tail_r  <= (tail_r == PTR_W'(POOL_SIZE - 1)) ? '0 : tail_r + 1'b1;
          count_r <= count_r + 1'b1;
        end else if (pop) begin
          count_r <= count_r - 1'b1;
        end
        if (mint) begin
          fresh_r <= fresh_r + 1'b1;
        end
        if (own_we) begin
          owned_r[own_idx] <= own_val;
        end
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result and bypass payload
  always_ff @(posedge clk) begin
    byp_data_r <= in_ch.handle;
    if (acc) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted_handle = granted_r;
  assign out_ch.status         = status_r;

  // queue never holds more handles than were minted
  a_count_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fresh_r)
    else $error("free fifo count exceeds minted handles");

  // exhaustion only once every handle is minted
  a_exhausted_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == fra_pkg::ST_EXHAUSTED) |-> fresh_r == CNT_W'(POOL_SIZE))
    else $error("exhausted reported with handles left to mint");

  // a good release clears the ownership bit
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.kind == fra_pkg::KIND_RELEASE) && (status_nxt == fra_pkg::ST_OK)
    |=> !owned_r[$past(in_ch.handle[OWN_W-1:0])])
    else $error("released handle still marked owned");

  // an accepted item always leaves a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
